// ===== src/rbcb_pkg.sv =====
`timescale 1ns / 1ps
package rbcb_pkg;

  // Fixed field widths
  localparam int HEAD_W = 17;
  localparam int CONE_W = 4;
  localparam int REL_W  = 17;

  // Angle accumulator in 1/65536 degree, bearing in 1/256 degree
  localparam int ZW    = 26;
  localparam int BW    = ZW - 8;
  localparam int RAW_W = BW + 1;

  localparam int OUT_TW = ((CONE_W + REL_W + 7) / 8) * 8;

  localparam int ATAN_IDX_W = 5;
  localparam int BORDER_CNT = 12;
  localparam int CONE_BINS  = BORDER_CNT - 1;

  localparam logic signed [ZW-1:0]    DEG90_Z   = 26'sd5898240;
  localparam logic signed [ZW-1:0]    ROUND_Z   = 26'sd128;
  localparam logic signed [BW-1:0]    FULL_B    = 18'sd92160;
  localparam logic signed [RAW_W-1:0] FULL_R    = 19'sd92160;
  localparam logic signed [RAW_W-1:0] HALF_R    = 19'sd46080;
  localparam logic signed [REL_W-1:0] CONE_LO   = -17'sd21760;
  localparam logic signed [REL_W-1:0] CONE_HI   = 17'sd21760;
  localparam logic signed [REL_W-1:0] REL_LIMIT = 17'sd46080;

  // Items that ride along the datapath untouched
  typedef struct packed {
    logic              zero;
    logic [HEAD_W-1:0] heading;
  } side_t;

  // atan(2^-i) in degrees * 65536, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [ZW-1:0] a;
    case (idx)
      5'd0:    a = 26'sd2949120;
      5'd1:    a = 26'sd1740967;
      5'd2:    a = 26'sd919879;
      5'd3:    a = 26'sd466945;
      5'd4:    a = 26'sd234379;
      5'd5:    a = 26'sd117304;
      5'd6:    a = 26'sd58666;
      5'd7:    a = 26'sd29335;
      5'd8:    a = 26'sd14668;
      5'd9:    a = 26'sd7334;
      5'd10:   a = 26'sd3667;
      5'd11:   a = 26'sd1833;
      5'd12:   a = 26'sd917;
      5'd13:   a = 26'sd458;
      5'd14:   a = 26'sd229;
      5'd15:   a = 26'sd115;
      5'd16:   a = 26'sd57;
      5'd17:   a = 26'sd29;
      5'd18:   a = 26'sd14;
      5'd19:   a = 26'sd7;
      5'd20:   a = 26'sd4;
      5'd21:   a = 26'sd2;
      5'd22:   a = 26'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Bin borders in 1/256 degree, from -85 up to 85 degrees
  function automatic logic signed [REL_W-1:0] cone_border(input logic [CONE_W-1:0] j);
    logic signed [REL_W-1:0] b;
    case (j)
      4'd0:    b = -17'sd21760;
      4'd1:    b = -17'sd15360;
      4'd2:    b = -17'sd10240;
      4'd3:    b = -17'sd6400;
      4'd4:    b = -17'sd3840;
      4'd5:    b = -17'sd1280;
      4'd6:    b = 17'sd1280;
      4'd7:    b = 17'sd3840;
      4'd8:    b = 17'sd6400;
      4'd9:    b = 17'sd10240;
      4'd10:   b = 17'sd15360;
      default: b = 17'sd21760;
    endcase
    return b;
  endfunction

  // Bin j (open left, closed right) maps to cone 12-j; outside gives 0
  function automatic logic [CONE_W-1:0] cone_of(input logic signed [REL_W-1:0] rel);
    logic [CONE_W-1:0] c;
    c = '0;
    for (int j = 1; j <= CONE_BINS; j++) begin
      if (rel > cone_border(CONE_W'(j - 1)) && rel <= cone_border(CONE_W'(j))) begin
        c = CONE_W'(BORDER_CNT - j);
      end
    end
    return c;
  endfunction

endpackage

// ===== src/rbcb_prep.sv =====
`timescale 1ns / 1ps
module rbcb_prep #(
  parameter int COORD_WIDTH = 24,
  parameter int DW          = 28
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [COORD_WIDTH-1:0]        origin_x,
  input  logic signed [COORD_WIDTH-1:0]        origin_y,
  input  logic signed [COORD_WIDTH-1:0]        target_x,
  input  logic signed [COORD_WIDTH-1:0]        target_y,
  input  logic [rbcb_pkg::HEAD_W-1:0]          heading,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [DW-1:0]                 x_o,
  output logic signed [DW-1:0]                 y_o,
  output logic signed [rbcb_pkg::ZW-1:0]       z_o,
  output rbcb_pkg::side_t                      side_o
);
  import rbcb_pkg::*;

  localparam int DXW = COORD_WIDTH + 1;

  logic [1:0]            v_r;
  logic [1:0]            en;
  logic signed [DXW-1:0] dx_r, dy_r;
  logic [HEAD_W-1:0]     head_r;
  logic signed [DW-1:0]  dxe, dye;
  logic signed [DW-1:0]  x_nxt, y_nxt;
  logic signed [ZW-1:0]  z_nxt;
  logic signed [DW-1:0]  x_r, y_r;
  logic signed [ZW-1:0]  z_r;
  side_t                 side_r;

  // Advance a stage when it is empty or its item moves on
  assign en[1]    = !v_r[1] || out_ready;
  assign en[0]    = !v_r[0] || en[1];
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
    end
  end

  // Stage 1: form the vector from origin to target
  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx_r   <= DXW'(target_x) - DXW'(origin_x);
      dy_r   <= DXW'(target_y) - DXW'(origin_y);
      head_r <= heading;
    end
  end

  // Stage 2: rotate a left half plane vector by +-90 degrees
  always_comb begin
    dxe = DW'(dx_r);
    dye = DW'(dy_r);
    if (dx_r < 0) begin
      if (dy_r >= 0) begin
        x_nxt = dye;
        y_nxt = -dxe;
        z_nxt = DEG90_Z;
      end else begin
        x_nxt = -dye;
        y_nxt = dxe;
        z_nxt = -DEG90_Z;
      end
    end else begin
      x_nxt = dxe;
      y_nxt = dye;
      z_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      x_r            <= x_nxt;
      y_r            <= y_nxt;
      z_r            <= z_nxt;
      side_r.zero    <= (dx_r == '0) && (dy_r == '0);
      side_r.heading <= head_r;
    end
  end

  assign out_valid = v_r[1];
  assign x_o       = x_r;
  assign y_o       = y_r;
  assign z_o       = z_r;
  assign side_o    = side_r;

endmodule

// ===== src/rbcb_cordic_stage.sv =====
`timescale 1ns / 1ps
module rbcb_cordic_stage #(
  parameter int DW  = 28,
  parameter int IDX = 0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [DW-1:0]           x_i,
  input  logic signed [DW-1:0]           y_i,
  input  logic signed [rbcb_pkg::ZW-1:0] z_i,
  input  rbcb_pkg::side_t                side_i,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [DW-1:0]           x_o,
  output logic signed [DW-1:0]           y_o,
  output logic signed [rbcb_pkg::ZW-1:0] z_o,
  output rbcb_pkg::side_t                side_o
);
  import rbcb_pkg::*;

  logic                 v_r;
  logic                 en;
  logic signed [DW-1:0] xs, ys;
  logic signed [DW-1:0] x_nxt, y_nxt;
  logic signed [ZW-1:0] z_nxt;
  logic signed [ZW-1:0] ang;
  logic signed [DW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  side_t                side_r;

  assign en       = !v_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  // Rotate toward the x axis; a zero residual counts as not positive
  always_comb begin
    xs  = x_i >>> IDX;
    ys  = y_i >>> IDX;
    ang = atan_q16(ATAN_IDX_W'(IDX));
    if (y_i > 0) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ang;
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      side_r <= side_i;
    end
  end

  assign out_valid = v_r;
  assign x_o       = x_r;
  assign y_o       = y_r;
  assign z_o       = z_r;
  assign side_o    = side_r;

endmodule

// ===== src/rbcb_post.sv =====
`timescale 1ns / 1ps
module rbcb_post (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [rbcb_pkg::ZW-1:0]    z_i,
  input  rbcb_pkg::side_t                   side_i,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rbcb_pkg::CONE_W-1:0]       cone_o,
  output logic signed [rbcb_pkg::REL_W-1:0] rel_o
);
  import rbcb_pkg::*;

  localparam int NST = 5;

  logic [NST-1:0]          v_r;
  logic [NST:0]            en;
  logic signed [ZW-1:0]    zr;
  logic signed [BW-1:0]    bear_r, bwrap_r, bwrap_nxt;
  logic [HEAD_W-1:0]       hd0_r, hd1_r;
  logic signed [RAW_W-1:0] raw_r, rel_nxt;
  logic signed [REL_W-1:0] rel3_r, rel4_r;
  logic [CONE_W-1:0]       cone_r;

  // Build the advance chain from the output back
  always_comb begin
    en[NST] = out_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // Round the accumulator to 1/256 degree, ties upward
  assign zr = z_i + ROUND_Z;

  // Wrap bearing to [0,360)
  always_comb begin
    bwrap_nxt = bear_r;
    if (bear_r < 0) begin
      bwrap_nxt = bear_r + FULL_B;
    end else if (bear_r >= FULL_B) begin
      bwrap_nxt = bear_r - FULL_B;
    end
  end

  // Wrap relative angle once to (-180,180]
  always_comb begin
    rel_nxt = raw_r;
    if (raw_r <= -HALF_R) begin
      rel_nxt = raw_r + FULL_R;
    end else if (raw_r > HALF_R) begin
      rel_nxt = raw_r - FULL_R;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      bear_r <= side_i.zero ? '0 : zr[ZW-1:8];
      hd0_r  <= side_i.heading;
    end
    if (en[1]) begin
      bwrap_r <= bwrap_nxt;
      hd1_r   <= hd0_r;
    end
    if (en[2]) begin
      raw_r <= RAW_W'(bwrap_r) - RAW_W'(signed'({1'b0, hd1_r}));
    end
    if (en[3]) begin
      rel3_r <= rel_nxt[REL_W-1:0];
    end
    if (en[4]) begin
      cone_r <= cone_of(rel3_r);
      rel4_r <= rel3_r;
    end
  end

  assign out_valid = v_r[NST-1];
  assign cone_o    = cone_r;
  assign rel_o     = rel4_r;

endmodule

// ===== src/relative_bearing_cone_binner_unit.sv =====
`timescale 1ns / 1ps
// Channel  Ports                       Payload (low bit first)
// -------  --------------------------  -------------------------------------------
// in       in_tvalid/in_tready/tdata   origin_x, origin_y, target_x, target_y,
//                                      heading (17b), zero padded to bytes
// out      out_tvalid/out_tready/tdata cone (4b), relative_angle (17b), zero pad
//
// The pipeline holds two prep stages, one register per CORDIC rotation and five
// stages for rounding, wrap and binning.
// One item enters per cycle unless stalled; every stage holds its own valid bit.
// A stall at the output holds only full stages; empty stages keep filling.
// Synchronous active-low reset empties the pipeline.
module relative_bearing_cone_binner_unit #(
  parameter int COORD_WIDTH       = 24,
  parameter int CORDIC_ITERATIONS = 18
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // origin_x, origin_y, target_x, target_y, heading, pad
  input  logic [((4*COORD_WIDTH+rbcb_pkg::HEAD_W+7)/8)*8-1:0] in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // cone, relative_angle, pad
  output logic [rbcb_pkg::OUT_TW-1:0] out_tdata
);
  import rbcb_pkg::*;

  localparam int DW = COORD_WIDTH + 4;
  localparam int CW = COORD_WIDTH;
  localparam int NI = CORDIC_ITERATIONS;

  logic                 vld [NI+1];
  logic                 rdy [NI+1];
  logic signed [DW-1:0] cx  [NI+1];
  logic signed [DW-1:0] cy  [NI+1];
  logic signed [ZW-1:0] cz  [NI+1];
  side_t                cs  [NI+1];
  logic [CONE_W-1:0]       cone;
  logic signed [REL_W-1:0] rel;

  // Difference and quadrant fold
  rbcb_prep #(
    .COORD_WIDTH(CW),
    .DW         (DW)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .origin_x (in_tdata[CW-1:0]),
    .origin_y (in_tdata[2*CW-1:CW]),
    .target_x (in_tdata[3*CW-1:2*CW]),
    .target_y (in_tdata[4*CW-1:3*CW]),
    .heading  (in_tdata[4*CW+HEAD_W-1:4*CW]),
    .out_valid(vld[0]),
    .out_ready(rdy[0]),
    .x_o      (cx[0]),
    .y_o      (cy[0]),
    .z_o      (cz[0]),
    .side_o   (cs[0])
  );

  // One register stage per rotation
  for (genvar i = 0; i < NI; i++) begin : g_rot
    rbcb_cordic_stage #(
      .DW (DW),
      .IDX(i)
    ) u_rot (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (vld[i]),
      .in_ready (rdy[i]),
      .x_i      (cx[i]),
      .y_i      (cy[i]),
      .z_i      (cz[i]),
      .side_i   (cs[i]),
      .out_valid(vld[i+1]),
      .out_ready(rdy[i+1]),
      .x_o      (cx[i+1]),
      .y_o      (cy[i+1]),
      .z_o      (cz[i+1]),
      .side_o   (cs[i+1])
    );
  end

  // Round, wrap, subtract heading and bin
  rbcb_post u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (vld[NI]),
    .in_ready (rdy[NI]),
    .z_i      (cz[NI]),
    .side_i   (cs[NI]),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .cone_o   (cone),
    .rel_o    (rel)
  );

  assign out_tdata = OUT_TW'({rel, cone});

  // A cone is reported only inside the outer borders
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (cone != '0) |-> (rel > CONE_LO) && (rel <= CONE_HI))
    else $error("cone set outside borders");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((rel <= CONE_LO) || (rel > CONE_HI)) |-> (cone == '0))
    else $error("angle outside borders not mapped to cone 0");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (rel > -REL_LIMIT) && (rel <= REL_LIMIT))
    else $error("relative angle not wrapped");

  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule
